[design/frb_pkg.sv]
// ----------------------------------------------------------------------------
// Frame ring buffer package
// Shared widths, codes, the command record and a small helper function.
// ----------------------------------------------------------------------------
`default_nettype none

package frb_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned LEN_W  = 7;
  localparam int unsigned CNT_W  = 5;
  localparam int unsigned FREE_W = 4;
  localparam int unsigned REJ_W  = 2;

  // Configuration register indexes
  localparam logic CFG_LEN_LIMIT = 1'b0;
  localparam logic CFG_SLOTS     = 1'b1;

  // Reject flags of the frame under construction
  localparam int unsigned REJ_FULL_BIT = 0;
  localparam int unsigned REJ_LONG_BIT = 1;

  typedef enum logic [1:0] {
    FN_WRITE = 2'd0,
    FN_READ  = 2'd1,
    FN_DROP  = 2'd2,
    FN_CLEAR = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_PARAM = 2'd3
  } status_e;

  // Command class decided by the front end
  typedef enum logic [2:0] {
    OP_WRITE,
    OP_READ,
    OP_READ_BAD,
    OP_DROP,
    OP_CLEAR
  } op_e;

  typedef struct packed {
    op_e               op;
    logic [BYTE_W-1:0] data;
    logic              eof;
    logic [LEN_W-1:0]  rlim;
  } cmd_t;

  // Free slots: slots minus count minus one, floored at zero
  function automatic logic [FREE_W-1:0] free_of(input logic [CNT_W-1:0] slots,
                                               input logic [CNT_W-1:0] cnt);
    logic [CNT_W-1:0] diff;
    diff = slots - cnt - CNT_W'(1);
    return (slots > cnt) ? FREE_W'(diff) : '0;
  endfunction

endpackage

`default_nettype wire

[design/frb_front.sv]
// ----------------------------------------------------------------------------
// Frame ring buffer front end
// Decodes an incoming transaction into a command class and checks the read
// buffer size against the active frame length limit.
// ----------------------------------------------------------------------------
`default_nettype none

module frb_front (
  input  wire logic [1:0]               func_i,
  input  wire logic [frb_pkg::BYTE_W-1:0] data_byte_i,
  input  wire logic                     end_of_frame_i,
  input  wire logic [frb_pkg::LEN_W-1:0] read_limit_i,
  input  wire logic [frb_pkg::LEN_W-1:0] len_limit_i,
  output frb_pkg::cmd_t                 cmd_o
);
  import frb_pkg::*;

  logic rlim_bad;

  // Reject a zero buffer size or one above the length limit
  assign rlim_bad = (read_limit_i == '0) || (read_limit_i > len_limit_i);

  // Classify the transaction
  always_comb begin
    cmd_o.data = data_byte_i;
    cmd_o.eof  = end_of_frame_i;
    cmd_o.rlim = read_limit_i;
    unique case (func_e'(func_i))
      FN_WRITE: cmd_o.op = OP_WRITE;
      FN_READ:  cmd_o.op = rlim_bad ? OP_READ_BAD : OP_READ;
      FN_DROP:  cmd_o.op = OP_DROP;
      FN_CLEAR: cmd_o.op = OP_CLEAR;
      default:  cmd_o.op = OP_CLEAR;
    endcase
  end

endmodule

`default_nettype wire

[design/frb_queue.sv]
// ----------------------------------------------------------------------------
// Frame ring buffer command queue
// Two-entry queue between the front end and the execution back end.
// ----------------------------------------------------------------------------
`default_nettype none

module frb_queue (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  frb_pkg::cmd_t      cmd_i,
  output logic               full_o,
  output logic               valid_o,
  output frb_pkg::cmd_t      cmd_o,
  input  wire logic          pop_i
);
  import frb_pkg::*;

  cmd_t       entry_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] fill_q, fill_d;

  assign full_o  = (fill_q == 2'd2);
  assign valid_o = (fill_q != 2'd0);
  assign cmd_o   = entry_q[rd_ptr_q];

  // Advance pointers and fill level
  always_comb begin
    wr_ptr_d = wr_ptr_q ^ push_i;
    rd_ptr_d = rd_ptr_q ^ pop_i;
    fill_d   = fill_q + 2'(push_i) - 2'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  // Hold queued commands
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

`default_nettype wire

[design/frb_back.sv]
// ----------------------------------------------------------------------------
// Frame ring buffer back end
// Executes queued commands against the slot ring: builds and commits frames,
// streams the oldest frame out one byte a cycle, drops and clears.
// ----------------------------------------------------------------------------
`default_nettype none

module frb_back #(
  parameter int unsigned FRAME_BYTES = 64,
  parameter int unsigned SLOT_COUNT  = 16
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      init_i,
  input  wire logic [frb_pkg::LEN_W-1:0] len_limit_i,
  input  wire logic [frb_pkg::CNT_W-1:0] slots_i,
  input  wire logic                      cmd_valid_i,
  input  frb_pkg::cmd_t                  cmd_i,
  output logic                           pop_o,
  output logic                           res_valid_o,
  output logic [1:0]                     status_o,
  output logic [frb_pkg::BYTE_W-1:0]     out_byte_o,
  output logic [frb_pkg::LEN_W-1:0]      frame_len_o,
  output logic                           last_o,
  output logic [frb_pkg::CNT_W-1:0]      frame_count_o,
  output logic [frb_pkg::CNT_W-1:0]      max_used_o,
  output logic [frb_pkg::FREE_W-1:0]     free_slots_o
);
  import frb_pkg::*;

  localparam int unsigned SlotW      = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int unsigned CmpW       = ((SlotW > CNT_W) ? SlotW : CNT_W) + 1;
  localparam int unsigned FrameDepth = SLOT_COUNT * FRAME_BYTES;
  localparam int unsigned AddrW      = (FrameDepth > 1) ? $clog2(FrameDepth) : 1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RDCHK,
    S_RUN
  } state_e;

  // Storage
  logic [BYTE_W-1:0] frame_mem [FrameDepth];
  logic [LEN_W-1:0]  len_mem   [SLOT_COUNT];
  logic [BYTE_W-1:0] fr_rd_q;
  logic [LEN_W-1:0]  len_rd_q;

  // Control state
  state_e            state_q, state_d;
  logic [SlotW-1:0]  head_q, head_d;
  logic [SlotW-1:0]  tail_q, tail_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [CNT_W-1:0]  hw_q, hw_d;
  logic [LEN_W-1:0]  off_q, off_d;
  logic [REJ_W-1:0]  rej_q, rej_d;
  logic [LEN_W-1:0]  rlim_q, rlim_d;
  logic [SlotW-1:0]  rd_slot_q, rd_slot_d;
  logic [LEN_W-1:0]  run_len_q, run_len_d;
  logic [LEN_W-1:0]  run_idx_q, run_idx_d;

  // Result register
  logic              res_valid_d;
  logic [1:0]        status_d;
  logic [BYTE_W-1:0] out_byte_d;
  logic [LEN_W-1:0]  frame_len_d;
  logic              last_d;
  logic [CNT_W-1:0]  frame_count_d;
  logic [CNT_W-1:0]  max_used_d;
  logic [FREE_W-1:0] free_slots_d;

  // Memory ports
  logic              fr_we;
  logic [AddrW-1:0]  fr_waddr;
  logic [AddrW-1:0]  fr_raddr;
  logic              len_we;
  logic [LEN_W-1:0]  len_wdata;

  // Result fields chosen by the command
  logic              emit;
  status_e           emit_st;
  logic [BYTE_W-1:0] emit_byte;
  logic [LEN_W-1:0]  emit_len;
  logic              emit_last;

  // Write-path intermediates
  logic              too_long;
  logic              ring_full;
  logic [REJ_W-1:0]  rej_n;
  logic [LEN_W-1:0]  off_n;
  logic [LEN_W-1:0]  run_nxt;

  function automatic logic [SlotW-1:0] next_slot(input logic [SlotW-1:0] s,
                                                 input logic [CNT_W-1:0] n);
    logic [CmpW-1:0] inc;
    inc = CmpW'(s) + CmpW'(1);
    return (inc >= CmpW'(n)) ? '0 : SlotW'(inc);
  endfunction

  function automatic logic [AddrW-1:0] frame_addr(input logic [SlotW-1:0] s,
                                                  input logic [LEN_W-1:0] o);
    return AddrW'(s) * AddrW'(FRAME_BYTES) + AddrW'(o);
  endfunction

  assign pop_o     = (state_q == S_IDLE) && cmd_valid_i;
  assign too_long  = (off_q >= len_limit_i);
  assign ring_full = (count_q >= slots_i);
  assign run_nxt   = run_idx_q + LEN_W'(1);

  // Work out the next state and the result of this cycle
  always_comb begin
    state_d   = state_q;
    head_d    = head_q;
    tail_d    = tail_q;
    count_d   = count_q;
    hw_d      = hw_q;
    off_d     = off_q;
    rej_d     = rej_q;
    rlim_d    = rlim_q;
    rd_slot_d = rd_slot_q;
    run_len_d = run_len_q;
    run_idx_d = run_idx_q;
    fr_we     = 1'b0;
    fr_waddr  = frame_addr(head_q, off_q);
    fr_raddr  = '0;
    len_we    = 1'b0;
    emit      = 1'b0;
    emit_st   = ST_OK;
    emit_byte = '0;
    emit_len  = '0;
    emit_last = 1'b1;
    rej_n     = rej_q;
    off_n     = off_q;
    len_wdata = off_q;

    unique case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          unique case (cmd_i.op)
            OP_WRITE: begin
              emit = 1'b1;
              // Append the byte unless the frame is too long or the ring full
              if (too_long) begin
                rej_n[REJ_LONG_BIT] = 1'b1;
              end else if (ring_full) begin
                rej_n[REJ_FULL_BIT] = 1'b1;
              end else begin
                fr_we = 1'b1;
                off_n = off_q + LEN_W'(1);
              end
              off_d     = off_n;
              rej_d     = rej_n;
              len_wdata = off_n;
              if (cmd_i.eof) begin
                off_d = '0;
                rej_d = '0;
                if (rej_n != '0) begin
                  emit_st = rej_n[REJ_LONG_BIT] ? ST_PARAM : ST_FULL;
                end else begin
                  // Commit the frame into the head slot
                  len_we   = 1'b1;
                  count_d  = count_q + CNT_W'(1);
                  head_d   = next_slot(head_q, slots_i);
                  emit_len = off_n;
                  if (count_d > hw_q) begin
                    hw_d = count_d;
                  end
                end
              end
            end
            OP_READ: begin
              if (count_q == '0) begin
                emit    = 1'b1;
                emit_st = ST_EMPTY;
              end else begin
                rlim_d  = cmd_i.rlim;
                state_d = S_RDCHK;
              end
            end
            OP_READ_BAD: begin
              emit    = 1'b1;
              emit_st = ST_PARAM;
            end
            OP_DROP: begin
              emit = 1'b1;
              if (count_q == '0) begin
                emit_st = ST_EMPTY;
              end else begin
                count_d = count_q - CNT_W'(1);
                tail_d  = next_slot(tail_q, slots_i);
              end
            end
            OP_CLEAR: begin
              emit    = 1'b1;
              head_d  = '0;
              tail_d  = '0;
              count_d = '0;
              off_d   = '0;
              rej_d   = '0;
            end
            default: begin
              emit = 1'b1;
            end
          endcase
        end
      end
      S_RDCHK: begin
        // Length of the oldest frame is now in the read register
        if (len_rd_q > rlim_q) begin
          emit    = 1'b1;
          emit_st = ST_PARAM;
          state_d = S_IDLE;
        end else begin
          count_d = count_q - CNT_W'(1);
          tail_d  = next_slot(tail_q, slots_i);
          if (len_rd_q == '0) begin
            emit    = 1'b1;
            state_d = S_IDLE;
          end else begin
            rd_slot_d = tail_q;
            run_len_d = len_rd_q;
            run_idx_d = '0;
            fr_raddr  = frame_addr(tail_q, '0);
            state_d   = S_RUN;
          end
        end
      end
      S_RUN: begin
        // Emit one byte, fetch the next
        emit      = 1'b1;
        emit_byte = fr_rd_q;
        emit_len  = run_len_q;
        emit_last = (run_nxt == run_len_q);
        run_idx_d = run_nxt;
        if (emit_last) begin
          state_d = S_IDLE;
        end else begin
          fr_raddr = frame_addr(rd_slot_q, run_nxt);
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // Re-initialise the ring on a configuration write
    if (init_i) begin
      state_d = S_IDLE;
      head_d  = '0;
      tail_d  = '0;
      count_d = '0;
      hw_d    = '0;
      off_d   = '0;
      rej_d   = '0;
      emit    = 1'b0;
      fr_we   = 1'b0;
      len_we  = 1'b0;
    end

    res_valid_d   = emit;
    status_d      = emit_st;
    out_byte_d    = emit_byte;
    frame_len_d   = emit_len;
    last_d        = emit_last;
    frame_count_d = count_d;
    max_used_d    = hw_d;
    free_slots_d  = free_of(slots_i, count_d);
  end

  // Hold state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      head_q        <= '0;
      tail_q        <= '0;
      count_q       <= '0;
      hw_q          <= '0;
      off_q         <= '0;
      rej_q         <= '0;
      rlim_q        <= '0;
      rd_slot_q     <= '0;
      run_len_q     <= '0;
      run_idx_q     <= '0;
      res_valid_o   <= 1'b0;
      status_o      <= '0;
      out_byte_o    <= '0;
      frame_len_o   <= '0;
      last_o        <= 1'b0;
      frame_count_o <= '0;
      max_used_o    <= '0;
      free_slots_o  <= '0;
    end else begin
      state_q       <= state_d;
      head_q        <= head_d;
      tail_q        <= tail_d;
      count_q       <= count_d;
      hw_q          <= hw_d;
      off_q         <= off_d;
      rej_q         <= rej_d;
      rlim_q        <= rlim_d;
      rd_slot_q     <= rd_slot_d;
      run_len_q     <= run_len_d;
      run_idx_q     <= run_idx_d;
      res_valid_o   <= res_valid_d;
      status_o      <= status_d;
      out_byte_o    <= out_byte_d;
      frame_len_o   <= frame_len_d;
      last_o        <= last_d;
      frame_count_o <= frame_count_d;
      max_used_o    <= max_used_d;
      free_slots_o  <= free_slots_d;
    end
  end

  // Frame byte memory
  always_ff @(posedge clk_i) begin
    if (fr_we) begin
      frame_mem[fr_waddr] <= cmd_i.data;
    end
    fr_rd_q <= frame_mem[fr_raddr];
  end

  // Frame length memory, read at the oldest slot
  always_ff @(posedge clk_i) begin
    if (len_we) begin
      len_mem[head_q] <= len_wdata;
    end
    len_rd_q <= len_mem[tail_q];
  end

endmodule

`default_nettype wire

[design/frame_ring_buffer_unit.sv]
// ----------------------------------------------------------------------------
// Frame ring buffer unit
// Ring of fixed-size frame slots with byte-wise frame build and frame read.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: a transaction is taken at a clock edge with start_i high
//   and busy_o low. func_i selects write byte, read oldest frame, drop oldest
//   frame or clear.
//   Result channel: result_valid_o marks each result for one cycle; every
//   command gives one result, a successful read gives one result per frame
//   byte, with last_o on the final one.
//   Flow: each command passes through the command queue and the registered
//   result outputs. A read checks the oldest frame's length, then streams its
//   bytes, one byte per cycle. Throughput: one single-result command per
//   cycle while the back end is idle; a read holds the back end through its
//   length check and byte stream. A two-entry command queue decouples the
//   front end; busy_o is high while it is full.
//   Configuration: cfg_we_i writes the register at cfg_idx_i and resets the
//   ring, including the high-water mark. Write only while idle.
//   Reset: the ring is empty, limit and slot count take their defaults.
//   The receiver cannot stall: results are not held.
// ----------------------------------------------------------------------------
`default_nettype none

module frame_ring_buffer_unit #(
  parameter int unsigned FRAME_BYTES = 64,
  parameter int unsigned SLOT_COUNT  = 16
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  output logic                             busy_o,
  input  wire logic [1:0]                  func_i,
  input  wire logic [frb_pkg::BYTE_W-1:0]  data_byte_i,
  input  wire logic                        end_of_frame_i,
  input  wire logic [frb_pkg::LEN_W-1:0]   read_limit_i,
  output logic                             result_valid_o,
  output logic [1:0]                       status_o,
  output logic [frb_pkg::BYTE_W-1:0]       out_byte_o,
  output logic [frb_pkg::LEN_W-1:0]        frame_len_o,
  output logic                             last_o,
  output logic [frb_pkg::CNT_W-1:0]        frame_count_o,
  output logic [frb_pkg::CNT_W-1:0]        max_used_o,
  output logic [frb_pkg::FREE_W-1:0]       free_slots_o,
  input  wire logic                        cfg_we_i,
  input  wire logic                        cfg_idx_i,
  input  wire logic [frb_pkg::LEN_W-1:0]   cfg_wdata_i
);
  import frb_pkg::*;

  localparam logic [LEN_W-1:0] LimitRst = LEN_W'(FRAME_BYTES);
  localparam logic [CNT_W-1:0] SlotsRst = (SLOT_COUNT >= 16) ? CNT_W'(16) : CNT_W'(SLOT_COUNT);
  localparam int unsigned      WideW    = 10;

  logic [LEN_W-1:0] limit_q, limit_d;
  logic [CNT_W-1:0] slots_q, slots_d;
  logic [CNT_W-1:0] slots_wr;
  logic             accept;
  logic             q_full;
  logic             q_valid;
  logic             pop;
  cmd_t             cmd_in;
  cmd_t             cmd_out;

  assign accept   = start_i && !busy_o;
  assign busy_o   = q_full;
  assign slots_wr = cfg_wdata_i[CNT_W-1:0];

  // Store configuration as effective, clamped values
  always_comb begin
    limit_d = limit_q;
    slots_d = slots_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_LEN_LIMIT: begin
          if (cfg_wdata_i == '0) begin
            limit_d = LEN_W'(1);
          end else if (cfg_wdata_i > LEN_W'(FRAME_BYTES)) begin
            limit_d = LEN_W'(FRAME_BYTES);
          end else begin
            limit_d = cfg_wdata_i;
          end
        end
        CFG_SLOTS: begin
          if (slots_wr == '0) begin
            slots_d = CNT_W'(1);
          end else if (WideW'(slots_wr) > WideW'(SLOT_COUNT)) begin
            slots_d = CNT_W'(SLOT_COUNT);
          end else begin
            slots_d = slots_wr;
          end
        end
        default: begin
          limit_d = limit_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LimitRst;
      slots_q <= SlotsRst;
    end else begin
      limit_q <= limit_d;
      slots_q <= slots_d;
    end
  end

  frb_front u_front (
    .func_i         (func_i),
    .data_byte_i    (data_byte_i),
    .end_of_frame_i (end_of_frame_i),
    .read_limit_i   (read_limit_i),
    .len_limit_i    (limit_q),
    .cmd_o          (cmd_in)
  );

  frb_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept),
    .cmd_i   (cmd_in),
    .full_o  (q_full),
    .valid_o (q_valid),
    .cmd_o   (cmd_out),
    .pop_i   (pop)
  );

  frb_back #(
    .FRAME_BYTES (FRAME_BYTES),
    .SLOT_COUNT  (SLOT_COUNT)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .init_i        (cfg_we_i),
    .len_limit_i   (limit_q),
    .slots_i       (slots_q),
    .cmd_valid_i   (q_valid),
    .cmd_i         (cmd_out),
    .pop_o         (pop),
    .res_valid_o   (result_valid_o),
    .status_o      (status_o),
    .out_byte_o    (out_byte_o),
    .frame_len_o   (frame_len_o),
    .last_o        (last_o),
    .frame_count_o (frame_count_o),
    .max_used_o    (max_used_o),
    .free_slots_o  (free_slots_o)
  );

endmodule

`default_nettype wire

[design/frb_checker.sv]
// ----------------------------------------------------------------------------
// Frame ring buffer port checker
// Watches the result channel of the top level over time.
// ----------------------------------------------------------------------------
`default_nettype none

module frb_checker (
  input wire logic                       clk_i,
  input wire logic                       rst_ni,
  input wire logic                       result_valid_o,
  input wire logic [1:0]                 status_o,
  input wire logic [frb_pkg::LEN_W-1:0]  frame_len_o,
  input wire logic                       last_o,
  input wire logic [frb_pkg::CNT_W-1:0]  frame_count_o,
  input wire logic [frb_pkg::CNT_W-1:0]  max_used_o
);
  import frb_pkg::*;

  // A read run streams without gaps
  a_run_contiguous: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !last_o |=> result_valid_o)
    else $error("read run broken by a gap");

  // Only a successful read of a non-empty frame spans several results
  a_run_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !last_o |-> (status_o == ST_OK) && (frame_len_o != '0))
    else $error("multi-result run without ok status or length");

  // High-water mark never below the current count
  a_high_water: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> max_used_o >= frame_count_o)
    else $error("high-water mark below frame count");

  // Within a run the frame length stays fixed
  a_run_len_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !last_o |=> $stable(frame_len_o))
    else $error("frame length changed within a read run");

endmodule

bind frame_ring_buffer_unit frb_checker u_frb_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .result_valid_o (result_valid_o),
  .status_o       (status_o),
  .frame_len_o    (frame_len_o),
  .last_o         (last_o),
  .frame_count_o  (frame_count_o),
  .max_used_o     (max_used_o)
);

`default_nettype wire

[tb/tb_frame_ring_buffer_unit.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Frame ring buffer unit testbench
// Drives byte writes, frame reads, drops and clears through the command port
// and checks every result against an in-bench model of the slot ring. The
// directed tests cover empty-ring, parameter, too-long and full cases. The
// random phases run at several limit and slot settings, with random gaps on
// the command side in all but one of them.
// ----------------------------------------------------------------------------

module tb_frame_ring_buffer_unit;
  import frb_pkg::*;

  localparam int unsigned FRAME_BYTES = 64;
  localparam int unsigned SLOT_COUNT  = 16;
  localparam int unsigned GAP_PCT     = 20;

  typedef struct {
    status_e            status;
    logic [BYTE_W-1:0]  out_val;
    logic [LEN_W-1:0]   len;
    logic               last;
    logic [CNT_W-1:0]   count;
    logic [CNT_W-1:0]   hw;
    logic [FREE_W-1:0]  free;
  } ring_result_t;

  logic               clk_i          = 1'b0;
  logic               rst_ni         = 1'b0;
  logic               start_i        = 1'b0;
  logic               busy_o;
  logic [1:0]         func_i         = FN_CLEAR;
  logic [BYTE_W-1:0]  data_byte_i    = '0;
  logic               end_of_frame_i = 1'b0;
  logic [LEN_W-1:0]   read_limit_i   = '0;
  logic               result_valid_o;
  logic [1:0]         status_o;
  logic [BYTE_W-1:0]  out_byte_o;
  logic [LEN_W-1:0]   frame_len_o;
  logic               last_o;
  logic [CNT_W-1:0]   frame_count_o;
  logic [CNT_W-1:0]   max_used_o;
  logic [FREE_W-1:0]  free_slots_o;
  logic               cfg_we_i       = 1'b0;
  logic               cfg_idx_i      = CFG_LEN_LIMIT;
  logic [LEN_W-1:0]   cfg_wdata_i    = '0;

  // Ring model state
  logic [BYTE_W-1:0]  slot_bytes [SLOT_COUNT][FRAME_BYTES];
  logic [LEN_W-1:0]   slot_len   [SLOT_COUNT];
  int unsigned        head_idx, tail_idx, frames_held, peak_frames, build_pos;
  logic [REJ_W-1:0]   build_reject;
  int unsigned        len_limit_reg, slots_reg;

  ring_result_t       expected_results[$];
  ring_result_t       want;
  int unsigned        mismatches;
  int unsigned        items_sent;
  bit                 gaps_on;

  frame_ring_buffer_unit #(
    .FRAME_BYTES(FRAME_BYTES),
    .SLOT_COUNT (SLOT_COUNT)
  ) uut (
    .clk_i,
    .rst_ni,
    .start_i,
    .busy_o,
    .func_i,
    .data_byte_i,
    .end_of_frame_i,
    .read_limit_i,
    .result_valid_o,
    .status_o,
    .out_byte_o,
    .frame_len_o,
    .last_o,
    .frame_count_o,
    .max_used_o,
    .free_slots_o,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_wdata_i
  );

  always #4 clk_i = ~clk_i;

  // Clamp the register values to their effective ranges
  function automatic int unsigned eff_len();
    if (len_limit_reg == 0) return 1;
    if (len_limit_reg > FRAME_BYTES) return FRAME_BYTES;
    return len_limit_reg;
  endfunction

  function automatic int unsigned eff_slots();
    if (slots_reg == 0) return 1;
    if (slots_reg > SLOT_COUNT) return SLOT_COUNT;
    return slots_reg;
  endfunction

  function automatic int unsigned next_slot(int unsigned s);
    return (s + 1 >= eff_slots()) ? 0 : s + 1;
  endfunction

  function automatic void empty_ring();
    head_idx     = 0;
    tail_idx     = 0;
    frames_held  = 0;
    peak_frames  = 0;
    build_pos    = 0;
    build_reject = '0;
  endfunction

  // Queue one expected result, taking the counters from the current state
  function automatic void expect_result(status_e st, logic [BYTE_W-1:0] val,
                                        int unsigned len, logic last);
    ring_result_t r;
    int unsigned  slots;
    slots     = eff_slots();
    r.status  = st;
    r.out_val = val;
    r.len     = LEN_W'(len);
    r.last    = last;
    r.count   = CNT_W'(frames_held);
    r.hw      = CNT_W'(peak_frames);
    r.free    = (slots > frames_held) ? FREE_W'(slots - frames_held - 1) : '0;
    expected_results.push_back(r);
  endfunction

  // Advance the ring model by one accepted command and queue its results
  function automatic void predict_ring(func_e f, logic [BYTE_W-1:0] d, logic eof,
                                       logic [LEN_W-1:0] rl);
    int unsigned slots, limit, len, slot;
    status_e     st;
    slots = eff_slots();
    limit = eff_len();
    if (head_idx >= slots) head_idx = 0;
    if (tail_idx >= slots) tail_idx = 0;
    case (f)
      FN_WRITE: begin
        if (build_pos >= limit) begin
          build_reject[REJ_LONG_BIT] = 1'b1;
        end else if (frames_held >= slots) begin
          build_reject[REJ_FULL_BIT] = 1'b1;
        end else begin
          slot_bytes[head_idx][build_pos] = d;
          build_pos++;
        end
        if (!eof) begin
          expect_result(ST_OK, '0, 0, 1'b1);
        end else begin
          if (build_reject == '0 && frames_held >= slots) build_reject[REJ_FULL_BIT] = 1'b1;
          if (build_reject != '0) begin
            st = build_reject[REJ_LONG_BIT] ? ST_PARAM : ST_FULL;
            build_pos    = 0;
            build_reject = '0;
            expect_result(st, '0, 0, 1'b1);
          end else begin
            len = build_pos;
            slot_len[head_idx] = LEN_W'(len);
            frames_held++;
            if (frames_held > peak_frames) peak_frames = frames_held;
            head_idx  = next_slot(head_idx);
            build_pos = 0;
            expect_result(ST_OK, '0, len, 1'b1);
          end
        end
      end
      FN_READ: begin
        if (rl == 0 || rl > limit) begin
          expect_result(ST_PARAM, '0, 0, 1'b1);
        end else if (frames_held == 0) begin
          expect_result(ST_EMPTY, '0, 0, 1'b1);
        end else begin
          slot = tail_idx;
          len  = slot_len[slot];
          if (len > FRAME_BYTES) len = FRAME_BYTES;
          if (len > rl) begin
            expect_result(ST_PARAM, '0, 0, 1'b1);
          end else begin
            frames_held--;
            tail_idx = next_slot(tail_idx);
            if (len == 0) begin
              expect_result(ST_OK, '0, 0, 1'b1);
            end else begin
              for (int unsigned i = 0; i < len; i++)
                expect_result(ST_OK, slot_bytes[slot][i], len, i + 1 == len);
            end
          end
        end
      end
      FN_DROP: begin
        if (frames_held == 0) begin
          expect_result(ST_EMPTY, '0, 0, 1'b1);
        end else begin
          frames_held--;
          tail_idx = next_slot(tail_idx);
          expect_result(ST_OK, '0, 0, 1'b1);
        end
      end
      default: begin
        head_idx     = 0;
        tail_idx     = 0;
        frames_held  = 0;
        build_pos    = 0;
        build_reject = '0;
        expect_result(ST_OK, '0, 0, 1'b1);
      end
    endcase
  endfunction

  // Present one command, optionally after random noise with start low, and hold it until taken
  task automatic send_cmd(func_e f, logic [BYTE_W-1:0] d, logic eof, logic [LEN_W-1:0] rl);
    logic blocked;
    if (gaps_on && $urandom_range(99) < GAP_PCT) begin
      start_i        <= 1'b0;
      func_i         <= 2'($urandom);
      data_byte_i    <= 8'($urandom);
      end_of_frame_i <= 1'($urandom);
      read_limit_i   <= 7'($urandom);
      @(posedge clk_i);
    end
    start_i        <= 1'b1;
    func_i         <= f;
    data_byte_i    <= d;
    end_of_frame_i <= eof;
    read_limit_i   <= rl;
    do begin
      @(negedge clk_i);
      blocked = busy_o;
      @(posedge clk_i);
    end while (blocked);
    predict_ring(f, d, eof, rl);
    items_sent++;
  endtask

  // Send a whole frame of random bytes, end-of-frame on the last one
  task automatic send_frame(int unsigned n);
    for (int unsigned i = 0; i < n; i++)
      send_cmd(FN_WRITE, 8'($urandom), i + 1 == n, 7'($urandom));
  endtask

  // Drop start and wait until every expected result has come back
  task automatic wait_idle();
    start_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(logic idx, int unsigned val);
    wait_idle();
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= LEN_W'(val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    if (idx == CFG_LEN_LIMIT) len_limit_reg = val & 7'h7f;
    else slots_reg = val & 5'h1f;
    empty_ring();
  endtask

  task automatic test_empty_ring();
    send_cmd(FN_READ, 8'h00, 1'b0, 7'd64);
    send_cmd(FN_READ, 8'h00, 1'b0, 7'd0);
    send_cmd(FN_READ, 8'h00, 1'b0, 7'd65);
    send_cmd(FN_READ, 8'hff, 1'b1, 7'd127);
    send_cmd(FN_DROP, 8'h00, 1'b0, 7'd0);
    send_cmd(FN_CLEAR, 8'hff, 1'b1, 7'd127);
  endtask

  task automatic test_frame_round_trip();
    send_cmd(FN_WRITE, 8'h00, 1'b0, 7'd0);
    send_cmd(FN_WRITE, 8'hff, 1'b0, 7'd0);
    send_cmd(FN_WRITE, 8'ha5, 1'b1, 7'd0);
    // Too small a buffer leaves the frame in place
    send_cmd(FN_READ, 8'h00, 1'b0, 7'd2);
    send_cmd(FN_READ, 8'h00, 1'b0, 7'd3);
    send_cmd(FN_WRITE, 8'h5a, 1'b1, 7'd0);
    send_cmd(FN_DROP, 8'h00, 1'b0, 7'd0);
    send_frame(2);
    // Clear also aborts the frame under construction
    send_cmd(FN_WRITE, 8'h81, 1'b0, 7'd0);
    send_cmd(FN_CLEAR, 8'h00, 1'b0, 7'd0);
    send_cmd(FN_READ, 8'h00, 1'b0, 7'd64);
  endtask

  task automatic test_reject_cases();
    // Frame over the length limit
    write_reg(CFG_LEN_LIMIT, 3);
    send_frame(4);
    send_frame(3);
    send_cmd(FN_READ, 8'h00, 1'b0, 7'd4);
    send_cmd(FN_READ, 8'h00, 1'b0, 7'd3);
    // Ring full, both on a byte before end of frame and on the end-of-frame byte
    write_reg(CFG_LEN_LIMIT, 64);
    write_reg(CFG_SLOTS, 1);
    send_frame(1);
    send_frame(2);
    send_frame(1);
    send_cmd(FN_READ, 8'h00, 1'b0, 7'd64);
  endtask

  function automatic int unsigned pick_frame_len();
    int unsigned lim, r;
    lim = eff_len();
    r   = $urandom_range(99);
    if (r < 80) return $urandom_range(1, (lim < 8) ? lim : 8);
    if (r < 92) return $urandom_range((lim > 1) ? lim - 1 : 1, lim);
    return $urandom_range(lim + 1, lim + 2);
  endfunction

  function automatic logic [LEN_W-1:0] pick_read_limit();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 70) return LEN_W'(eff_len());
    if (r < 85) return LEN_W'($urandom_range(1, eff_len()));
    return LEN_W'($urandom_range(0, 127));
  endfunction

  // Mostly well-formed frames and reads with random content, some noise
  task automatic test_random_traffic(int unsigned len_lim, int unsigned slots,
                                     int unsigned n_items);
    int unsigned stop_at, r;
    write_reg(CFG_LEN_LIMIT, len_lim);
    write_reg(CFG_SLOTS, slots);
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) begin
      r = $urandom_range(99);
      if (r < 50) send_frame(pick_frame_len());
      else if (r < 80) send_cmd(FN_READ, 8'($urandom), 1'($urandom), pick_read_limit());
      else if (r < 88) send_cmd(FN_DROP, 8'($urandom), 1'($urandom), 7'($urandom));
      else if (r < 90) send_cmd(FN_CLEAR, 8'($urandom), 1'($urandom), 7'($urandom));
      else send_cmd(func_e'($urandom_range(0, 3)), 8'($urandom), 1'($urandom), 7'($urandom));
    end
  endtask

  // Compare one field and count the mismatch
  task automatic check_field(string name, logic [BYTE_W-1:0] exp_v, logic [BYTE_W-1:0] got_v);
    if (got_v !== exp_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, got_v);
      mismatches++;
    end
  endtask

  // Check each result mid-cycle against the oldest expectation
  always @(negedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      if (expected_results.size() == 0) begin
        $error("result with nothing expected: status %0d byte %0d", status_o, out_byte_o);
        mismatches++;
      end else begin
        want = expected_results.pop_front();
        check_field("status", want.status, status_o);
        check_field("out_byte", want.out_val, out_byte_o);
        check_field("frame_len", want.len, frame_len_o);
        check_field("last", want.last, last_o);
        check_field("frame_count", want.count, frame_count_o);
        check_field("max_used", want.hw, max_used_o);
        check_field("free_slots", want.free, free_slots_o);
      end
    end
  end

  // Overall time limit
  initial begin
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end

  initial begin
    mismatches    = 0;
    items_sent    = 0;
    gaps_on       = 1'b1;
    len_limit_reg = 64;
    slots_reg     = 16;
    empty_ring();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_ring();
    test_frame_round_trip();
    test_reject_cases();

    test_random_traffic(64, 16, 100);
    test_random_traffic(1, 1, 60);
    test_random_traffic(64, 1, 60);
    // Back-to-back commands with no gaps at all
    gaps_on = 1'b0;
    test_random_traffic(1, 16, 60);
    gaps_on = 1'b1;
    test_random_traffic($urandom_range(2, 63), $urandom_range(2, 15), 90);

    wait_idle();
    repeat (16) @(posedge clk_i);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
